FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the terminator shader checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, switched off while in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/dnts_pkg.sv
// ----------------------------------------------------------------------------
// dnts_pkg
// Types, constants and sine tables shared by the terminator shader blocks.
// ----------------------------------------------------------------------------
package dnts_pkg;

    // map geometry
    localparam int MAP_WIDTH  = 144;
    localparam int MAP_HEIGHT = 72;
    localparam int LAT_SPAN   = 2 * MAP_HEIGHT;

    // reciprocals for the column and row divisions (floor of 2^32 / divisor)
    localparam logic [31:0] LON_RECIP = 32'((64'd1 << 32) / MAP_WIDTH);
    localparam logic [31:0] LAT_RECIP = 32'((64'd1 << 32) / LAT_SPAN);

    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    // pipeline depth, input register to output register
    localparam int STAGES = 8;

    typedef logic [15:0]        angle_t;
    typedef logic signed [17:0] sine_t;
    typedef logic [16:0]        qval_t;

    typedef enum logic [1:0] {
        CFG_SUN_LONGITUDE   = 2'd0,
        CFG_SUN_DECLINATION = 2'd1,
        CFG_MONO_MODE       = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] column;
        logic [6:0] row;
        logic [7:0] day_pixel;
        logic [7:0] night_pixel;
    } src_item_t;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       in_night;
    } dst_item_t;

    typedef struct packed {
        logic [15:0]        sun_longitude;
        logic signed [13:0] sun_declination;
        logic               mono_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] day_pixel;
        logic [7:0] night_pixel;
    } pix_pair_t;

    // stage enables for two- and three-stage sections
    typedef struct packed {
        logic st1;
        logic st2;
    } pair_en_t;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } trio_en_t;

    // quarter-wave sine, Q16, at multiples of pi/32
    function automatic qval_t quarter_base(input logic [4:0] idx);
        unique case (idx)
            5'd0:    return 17'd0;
            5'd1:    return 17'd6424;
            5'd2:    return 17'd12785;
            5'd3:    return 17'd19024;
            5'd4:    return 17'd25080;
            5'd5:    return 17'd30893;
            5'd6:    return 17'd36410;
            5'd7:    return 17'd41576;
            5'd8:    return 17'd46341;
            5'd9:    return 17'd50660;
            5'd10:   return 17'd54491;
            5'd11:   return 17'd57798;
            5'd12:   return 17'd60547;
            5'd13:   return 17'd62714;
            5'd14:   return 17'd64277;
            5'd15:   return 17'd65220;
            5'd16:   return 17'd65536;
            default: return 17'd0;
        endcase
    endfunction

    // slope to the next table point; flat at the top of the quarter
    function automatic qval_t quarter_step(input logic [4:0] idx);
        if (idx >= 5'd16)
            return 17'd0;
        return quarter_base(idx + 5'd1) - quarter_base(idx);
    endfunction

endpackage

FILE: design/dnts_angle.sv
// ----------------------------------------------------------------------------
// dnts_angle
// Two stages: maps column and row to longitude and latitude angles and forms
// the declination, latitude and hour angles.
// ----------------------------------------------------------------------------
module dnts_angle (
    input  logic               clk,
    input  dnts_pkg::pair_en_t en,
    input  dnts_pkg::cfg_t     cfg,
    input  logic [7:0]         column,
    input  logic [6:0]         row,
    output dnts_pkg::angle_t   dec_angle,
    output dnts_pkg::angle_t   lat_angle,
    output dnts_pkg::angle_t   hour_angle
);

    // stage 1: reciprocal estimates, never above the true quotient
    logic [39:0] lon_mul;
    logic [38:0] lat_mul;
    logic [23:0] lon_q0_reg;
    logic [22:0] lat_q0_reg;
    logic [7:0]  col_s1_reg;
    logic [6:0]  row_s1_reg;

    assign lon_mul = 40'(column) * 40'(dnts_pkg::LON_RECIP);
    assign lat_mul = 39'(row) * 39'(dnts_pkg::LAT_RECIP);

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            lon_q0_reg <= lon_mul[39:16];
            lat_q0_reg <= lat_mul[38:16];
            col_s1_reg <= column;
            row_s1_reg <= row;
        end
    end

    // stage 2: one-step correction, then the angle arithmetic
    logic [34:0]       lon_back;
    logic [33:0]       lat_back;
    logic [23:0]       lon_rem;
    logic [22:0]       lat_rem;
    logic              lon_fix;
    logic              lat_fix;
    dnts_pkg::angle_t  lon;
    dnts_pkg::angle_t  lat_next;
    dnts_pkg::angle_t  dec_next;
    dnts_pkg::angle_t  hour_next;
    dnts_pkg::angle_t  dec_reg;
    dnts_pkg::angle_t  lat_reg;
    dnts_pkg::angle_t  hour_reg;

    always_comb
    begin
        lon_back  = 35'(lon_q0_reg) * 35'(dnts_pkg::MAP_WIDTH);
        lat_back  = 34'(lat_q0_reg) * 34'(dnts_pkg::LAT_SPAN);
        lon_rem   = {col_s1_reg, 16'd0} - lon_back[23:0];
        lat_rem   = {row_s1_reg, 16'd0} - lat_back[22:0];
        lon_fix   = (lon_rem >= 24'(dnts_pkg::MAP_WIDTH));
        lat_fix   = (lat_rem >= 23'(dnts_pkg::LAT_SPAN));
        lon       = lon_q0_reg[15:0] + 16'(lon_fix);
        lat_next  = lat_q0_reg[15:0] + 16'(lat_fix) - dnts_pkg::QUARTER_TURN;
        hour_next = cfg.sun_longitude - lon;
        dec_next  = {{2{cfg.sun_declination[13]}}, cfg.sun_declination};
    end

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            dec_reg  <= dec_next;
            lat_reg  <= lat_next;
            hour_reg <= hour_next;
        end
    end

    assign dec_angle  = dec_reg;
    assign lat_angle  = lat_reg;
    assign hour_angle = hour_reg;

endmodule

FILE: design/dnts_sine.sv
// ----------------------------------------------------------------------------
// dnts_sine
// Two-stage Q16 sine or cosine of a 16-bit circle angle, by linear
// interpolation in the quarter-wave table.
// ----------------------------------------------------------------------------
module dnts_sine (
    input  logic               clk,
    input  dnts_pkg::pair_en_t en,
    input  dnts_pkg::angle_t   angle,
    input  logic               cos_sel,
    output dnts_pkg::sine_t    value
);

    // stage 1: quadrant fold, table lookup and slope product
    logic [1:0]        quad;
    logic [14:0]       qpos;
    logic [4:0]        idx;
    logic [9:0]        frac;
    logic [26:0]       slope_prod;
    dnts_pkg::qval_t   base_reg;
    dnts_pkg::qval_t   part_reg;
    logic              neg_reg;

    always_comb
    begin
        // cosine is the sine a quarter turn on
        quad       = angle[15:14] + {1'b0, cos_sel};
        qpos       = quad[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
        idx        = qpos[14:10];
        frac       = qpos[9:0];
        slope_prod = 27'(dnts_pkg::quarter_step(idx)) * 27'(frac);
    end

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            base_reg <= dnts_pkg::quarter_base(idx);
            part_reg <= slope_prod[26:10];
            neg_reg  <= quad[1];
        end
    end

    // stage 2: sum and sign
    logic [17:0]     mag;
    dnts_pkg::sine_t value_reg;

    assign mag = 18'(base_reg) + 18'(part_reg);

    always_ff @(posedge clk)
    begin
        if (en.st2)
            value_reg <= neg_reg ? -$signed(mag) : $signed(mag);
    end

    assign value = value_reg;

endmodule

FILE: design/dnts_combine.sv
// ----------------------------------------------------------------------------
// dnts_combine
// Three stages of exact products for the law of cosines, then the sign of
//   C = sd*sl*65536 + cd*cl*ch
// as seen by the output register.
// ----------------------------------------------------------------------------
module dnts_combine (
    input  logic               clk,
    input  dnts_pkg::trio_en_t en,
    input  dnts_pkg::sine_t    sd,
    input  dnts_pkg::sine_t    cd,
    input  dnts_pkg::sine_t    sl,
    input  dnts_pkg::sine_t    cl,
    input  dnts_pkg::sine_t    ch,
    output logic               neg,
    output logic               nonpos
);

    // stage 1: the two 18x18 products
    logic signed [35:0] sdsl_reg;
    logic signed [35:0] cdcl_reg;
    dnts_pkg::sine_t    ch_reg;

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            sdsl_reg <= 36'(sd) * 36'(sl);
            cdcl_reg <= 36'(cd) * 36'(cl);
            ch_reg   <= ch;
        end
    end

    // stage 2: cd*cl*ch as two partial products, high and low halves
    logic signed [18:0] cdcl_hi;
    logic signed [17:0] cdcl_lo;
    logic signed [36:0] hi_prod_reg;
    logic signed [35:0] lo_prod_reg;
    logic signed [35:0] sdsl_s2_reg;

    assign cdcl_hi = cdcl_reg[35:17];
    assign cdcl_lo = $signed({1'b0, cdcl_reg[16:0]});

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            hi_prod_reg <= 37'(cdcl_hi) * 37'(ch_reg);
            lo_prod_reg <= 36'(cdcl_lo) * 36'(ch_reg);
            sdsl_s2_reg <= sdsl_reg;
        end
    end

    // stage 3: recombine the partial products
    logic signed [53:0] term_reg;
    logic signed [35:0] sdsl_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en.st3)
        begin
            term_reg    <= (54'(hi_prod_reg) <<< 17) + 54'(lo_prod_reg);
            sdsl_s3_reg <= sdsl_s2_reg;
        end
    end

    // final sum and sign test
    logic signed [53:0] c_sum;

    assign c_sum  = (54'(sdsl_s3_reg) <<< 16) + term_reg;
    assign neg    = c_sum[53];
    assign nonpos = c_sum[53] || (c_sum == 54'sd0);

endmodule

FILE: design/day_night_terminator_shader_unit.sv
// ----------------------------------------------------------------------------
// day_night_terminator_shader_unit
// Shades world-map pixels as day or night from the configured sun position.
// ----------------------------------------------------------------------------
// Usage:
//   src channel carries one map pixel per item (column, row, day and night
//   bytes); dst channel returns the shaded byte and the night flag. Both use
//   valid/stall: an item moves at a clock edge with valid high, stall low.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   0 sun longitude, 1 sun declination, 2 mono mode; other indexes ignored.
//   Write it only while no item is in flight.
//   One item per cycle is sustained while dst_stall is low. Depth, from
//   acceptance to dst_valid, is set by the angle mapping (2 stages), the table
//   sine units (2 stages), the product chain (3 stages) and the output register.
//   Reset (rst_n low, asynchronous) empties the pipeline and clears the
//   configuration to zero.
//   While dst_stall is high the output holds; earlier stages keep moving
//   into empty slots, and src_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module day_night_terminator_shader_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                src_valid,
    output logic                src_stall,
    input  dnts_pkg::src_item_t src_item,
    output logic                dst_valid,
    input  logic                dst_stall,
    output dnts_pkg::dst_item_t dst_item
);

    // configuration registers
    dnts_pkg::cfg_t cfg_reg;
    dnts_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (dnts_pkg::cfg_index_t'(cfg_index))
                dnts_pkg::CFG_SUN_LONGITUDE:   cfg_next.sun_longitude   = cfg_data;
                dnts_pkg::CFG_SUN_DECLINATION: cfg_next.sun_declination = cfg_data[13:0];
                dnts_pkg::CFG_MONO_MODE:       cfg_next.mono_mode       = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // valid bits and per-stage load enables; a stage loads when empty or
    // when the stage after it loads
    logic [dnts_pkg::STAGES-1:0] valid_reg;
    logic [dnts_pkg::STAGES-1:0] valid_next;
    logic [dnts_pkg::STAGES-1:0] en;

    always_comb
    begin
        en[dnts_pkg::STAGES-1] = !valid_reg[dnts_pkg::STAGES-1] || !dst_stall;
        for (int k = dnts_pkg::STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < dnts_pkg::STAGES; k++)
        begin
            if (en[k])
                valid_next[k] = (k == 0) ? src_valid : valid_reg[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign src_stall = !en[0];
    assign dst_valid = valid_reg[dnts_pkg::STAGES-1];

    // day and night bytes ride alongside the arithmetic
    dnts_pkg::pix_pair_t pix_reg [dnts_pkg::STAGES-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pix_reg[0].day_pixel   <= src_item.day_pixel;
            pix_reg[0].night_pixel <= src_item.night_pixel;
        end
        for (int k = 1; k < dnts_pkg::STAGES - 1; k++)
        begin
            if (en[k])
                pix_reg[k] <= pix_reg[k-1];
        end
    end

    // angles (stages 1-2)
    dnts_pkg::pair_en_t ang_en;
    dnts_pkg::angle_t   dec_angle;
    dnts_pkg::angle_t   lat_angle;
    dnts_pkg::angle_t   hour_angle;

    assign ang_en.st1 = en[0];
    assign ang_en.st2 = en[1];

    dnts_angle u_angle (
        .clk        (clk),
        .en         (ang_en),
        .cfg        (cfg_reg),
        .column     (src_item.column),
        .row        (src_item.row),
        .dec_angle  (dec_angle),
        .lat_angle  (lat_angle),
        .hour_angle (hour_angle)
    );

    // sines and cosines (stages 3-4)
    dnts_pkg::pair_en_t sin_en;
    dnts_pkg::sine_t    sd;
    dnts_pkg::sine_t    cd;
    dnts_pkg::sine_t    sl;
    dnts_pkg::sine_t    cl;
    dnts_pkg::sine_t    ch;

    assign sin_en.st1 = en[2];
    assign sin_en.st2 = en[3];

    dnts_sine u_sin_dec (
        .clk (clk), .en (sin_en), .angle (dec_angle), .cos_sel (1'b0), .value (sd)
    );

    dnts_sine u_cos_dec (
        .clk (clk), .en (sin_en), .angle (dec_angle), .cos_sel (1'b1), .value (cd)
    );

    dnts_sine u_sin_lat (
        .clk (clk), .en (sin_en), .angle (lat_angle), .cos_sel (1'b0), .value (sl)
    );

    dnts_sine u_cos_lat (
        .clk (clk), .en (sin_en), .angle (lat_angle), .cos_sel (1'b1), .value (cl)
    );

    dnts_sine u_cos_hour (
        .clk (clk), .en (sin_en), .angle (hour_angle), .cos_sel (1'b1), .value (ch)
    );

    // products and sign (stages 5-7)
    dnts_pkg::trio_en_t cmb_en;
    logic               c_neg;
    logic               c_nonpos;

    assign cmb_en.st1 = en[4];
    assign cmb_en.st2 = en[5];
    assign cmb_en.st3 = en[6];

    dnts_combine u_combine (
        .clk    (clk),
        .en     (cmb_en),
        .sd     (sd),
        .cd     (cd),
        .sl     (sl),
        .cl     (cl),
        .ch     (ch),
        .neg    (c_neg),
        .nonpos (c_nonpos)
    );

    // output register (stage 8)
    dnts_pkg::dst_item_t out_reg;
    dnts_pkg::dst_item_t out_next;

    always_comb
    begin
        out_next.in_night = c_nonpos;
        if (cfg_reg.mono_mode)
            out_next.out_pixel = {7'd0, c_neg ^ pix_reg[dnts_pkg::STAGES-2].day_pixel[0]};
        else if (c_nonpos)
            out_next.out_pixel = pix_reg[dnts_pkg::STAGES-2].night_pixel;
        else
            out_next.out_pixel = pix_reg[dnts_pkg::STAGES-2].day_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (en[dnts_pkg::STAGES-1])
            out_reg <= out_next;
    end

    assign dst_item = out_reg;

endmodule

FILE: design/dnts_checker.sv
// ----------------------------------------------------------------------------
// dnts_checker
// Port-level checks for the terminator shader, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dnts_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                src_valid,
    input  logic                src_stall,
    input  dnts_pkg::src_item_t src_item,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  dnts_pkg::dst_item_t dst_item
);

    // acceptance and free-output history, newest edge in bit 0
    logic [7:0] take_hist_reg;
    logic [6:0] free_hist_reg;
    logic       mono_reg;
    logic       src_take;

    assign src_take = src_valid && !src_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_hist_reg <= '0;
            free_hist_reg <= '0;
            mono_reg      <= 1'b0;
        end
        else
        begin
            take_hist_reg <= {take_hist_reg[6:0], src_take};
            free_hist_reg <= {free_hist_reg[5:0], !dst_stall};
            if (cfg_we && (cfg_index == 2'(dnts_pkg::CFG_MONO_MODE)))
                mono_reg <= cfg_data[0];
        end
    end

    // a held result stays put
    `ASSERT_NXT(a_dst_hold, clk, rst_n, dst_valid && dst_stall, dst_valid && $stable(dst_item))

    // with the output free, the pipeline always takes a new item
    `ASSERT_IMP(a_src_free, clk, rst_n, !dst_stall, !src_stall)

    // an item flowing unstalled reaches the output
    `ASSERT_IMP(a_latency, clk, rst_n, take_hist_reg[7] && (&free_hist_reg), dst_valid)

    // mono results use bit 0 only
    `ASSERT_IMP(a_mono_bits, clk, rst_n, dst_valid && mono_reg, dst_item.out_pixel[7:1] == 7'd0)

endmodule

bind day_night_terminator_shader_unit dnts_checker u_checker (.*);
